// ===== rtl/alu8f_pkg.sv =====
// Shared types and operation codes of the eight-bit ALU with flags.
`default_nettype none

package alu8f_pkg;

  // Operation codes carried on the action field.
  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_XOR  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_CP   = 5'd7,
    ACT_INC  = 5'd8,
    ACT_DEC  = 5'd9,
    ACT_RLC  = 5'd10,
    ACT_RRC  = 5'd11,
    ACT_RL   = 5'd12,
    ACT_RR   = 5'd13,
    ACT_SLA  = 5'd14,
    ACT_SRA  = 5'd15,
    ACT_SWAP = 5'd16,
    ACT_SRL  = 5'd17,
    ACT_BIT  = 5'd18,
    ACT_RES  = 5'd19,
    ACT_SET  = 5'd20,
    ACT_DAA  = 5'd21,
    ACT_CPL  = 5'd22,
    ACT_SCF  = 5'd23,
    ACT_CCF  = 5'd24,
    ACT_RLCA = 5'd25,
    ACT_RRCA = 5'd26,
    ACT_RLA  = 5'd27,
    ACT_RRA  = 5'd28
  } action_e;

  // Flags in their packed order: Z in bit 3 down to C in bit 0.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // What the datapath hands to the result register.
  typedef struct packed {
    logic [7:0] value;
    flags_t     flags;
    logic       write;
  } alu_out_t;

  localparam logic [7:0] DAA_LIMIT    = 8'h99;
  localparam logic [7:0] DAA_ADJ_HIGH = 8'h60;
  localparam logic [7:0] DAA_ADJ_LOW  = 8'h06;
  localparam logic [3:0] DAA_NIB_MAX  = 4'h9;

endpackage

`default_nettype wire

// ===== rtl/eight_bit_alu_with_flags.sv =====
// Top level of the eight-bit ALU with Z N H C flags: input and result registers.
`default_nettype none

// An item is taken on every rising edge at which start is high; busy is always low,
// because the block keeps no state between items and the receiver cannot stall it.
// Each item passes through an input register, one pass of combinational logic and
// a result register, from which its result is driven with result_valid_o high. One
// item can follow another in every cycle. Results leave in the order the items came
// in, each for one cycle only.

module eight_bit_alu_with_flags (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic [4:0] action_i,
  input  wire logic [7:0] operand_a_i,
  input  wire logic [7:0] operand_b_i,
  input  wire logic [2:0] bit_index_i,
  input  wire logic [3:0] flags_in_i,
  output      logic       result_valid_o,
  output      logic [7:0] result_o,
  output      logic [3:0] flags_out_o,
  output      logic       write_result_o
);

  logic                   accept;
  logic                   valid_q;
  logic [4:0]             action_q;
  logic [7:0]             a_q;
  logic [7:0]             b_q;
  logic [2:0]             bit_q;
  alu8f_pkg::flags_t      flags_q;
  alu8f_pkg::alu_out_t    calc_d;
  alu8f_pkg::alu_out_t    out_q;
  logic                   out_valid_q;

  // No item ever has to wait, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Stage one: the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      a_q      <= operand_a_i;
      b_q      <= operand_b_i;
      bit_q    <= bit_index_i;
      flags_q  <= alu8f_pkg::flags_t'(flags_in_i);
    end
  end

  alu8f_calc u_calc (
    .action_i    (action_q),
    .operand_a_i (a_q),
    .operand_b_i (b_q),
    .bit_index_i (bit_q),
    .flags_i     (flags_q),
    .out_o       (calc_d)
  );

  // Stage two: the result register, which drives the output ports directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      out_q <= calc_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q.value;
  assign flags_out_o    = out_q.flags;
  assign write_result_o = out_q.write;

  // Every accepted item reaches the result stage after passing the input register.
  a_accept_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o)
    else $error("accepted item did not produce a result");

  // A result strobe only ever follows a filled input stage.
  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(valid_q))
    else $error("result strobe without an item behind it");

  // Whenever nothing is written back, the result is the register value unchanged.
  a_nowrite_keeps_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !calc_d.write |-> calc_d.value == a_q)
    else $error("unwritten result differs from the operand");

  // Compare and the flag-only operations never request a write-back.
  a_cp_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (action_q == alu8f_pkg::ACT_CP || action_q == alu8f_pkg::ACT_BIT ||
                action_q == alu8f_pkg::ACT_SCF || action_q == alu8f_pkg::ACT_CCF)
    |-> !calc_d.write)
    else $error("write-back requested for a flag-only operation");

endmodule

`default_nettype wire

// ===== rtl/alu8f_calc.sv =====
// Combinational datapath of the eight-bit ALU: result, flags and write-enable.
`default_nettype none

module alu8f_calc (
  input  wire logic [4:0]        action_i,
  input  wire logic [7:0]        operand_a_i,
  input  wire logic [7:0]        operand_b_i,
  input  wire logic [2:0]        bit_index_i,
  input  wire alu8f_pkg::flags_t flags_i,
  output alu8f_pkg::alu_out_t    out_o
);

  logic       c_add;
  logic       c_sub;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] diff9;
  logic [4:0] hdiff5;
  logic [7:0] inc8;
  logic [7:0] dec8;
  logic [7:0] mask8;
  logic [7:0] rot_res;
  logic       rot_cy;
  logic [7:0] daa_u;
  logic       daa_cy;
  logic [7:0] daa_res;
  logic [7:0] res;
  alu8f_pkg::flags_t fo;
  logic       wr;

  assign c_add = (action_i == alu8f_pkg::ACT_ADC) & flags_i.c;
  assign c_sub = (action_i == alu8f_pkg::ACT_SBC) & flags_i.c;

  assign sum9   = {1'b0, operand_a_i} + {1'b0, operand_b_i} + {8'd0, c_add};
  assign hsum5  = {1'b0, operand_a_i[3:0]} + {1'b0, operand_b_i[3:0]} + {4'd0, c_add};
  // The borrow is taken over the whole value: the top bit is set when negative.
  assign diff9  = {1'b0, operand_a_i} - {1'b0, operand_b_i} - {8'd0, c_sub};
  assign hdiff5 = {1'b0, operand_a_i[3:0]} - {1'b0, operand_b_i[3:0]} - {4'd0, c_sub};

  assign inc8  = operand_a_i + 8'd1;
  assign dec8  = operand_a_i - 8'd1;
  assign mask8 = 8'd1 << bit_index_i;

  // Rotates and shifts, shared by the prefixed and the accumulator forms.
  always_comb begin
    rot_res = operand_a_i;
    rot_cy  = 1'b0;
    case (action_i)
      alu8f_pkg::ACT_RLC, alu8f_pkg::ACT_RLCA: begin
        rot_cy  = operand_a_i[7];
        rot_res = {operand_a_i[6:0], operand_a_i[7]};
      end
      alu8f_pkg::ACT_RRC, alu8f_pkg::ACT_RRCA: begin
        rot_cy  = operand_a_i[0];
        rot_res = {operand_a_i[0], operand_a_i[7:1]};
      end
      alu8f_pkg::ACT_RL, alu8f_pkg::ACT_RLA: begin
        rot_cy  = operand_a_i[7];
        rot_res = {operand_a_i[6:0], flags_i.c};
      end
      alu8f_pkg::ACT_RR, alu8f_pkg::ACT_RRA: begin
        rot_cy  = operand_a_i[0];
        rot_res = {flags_i.c, operand_a_i[7:1]};
      end
      alu8f_pkg::ACT_SLA: begin
        rot_cy  = operand_a_i[7];
        rot_res = {operand_a_i[6:0], 1'b0};
      end
      alu8f_pkg::ACT_SRA: begin
        rot_cy  = operand_a_i[0];
        rot_res = {operand_a_i[7], operand_a_i[7:1]};
      end
      alu8f_pkg::ACT_SWAP: begin
        rot_cy  = 1'b0;
        rot_res = {operand_a_i[3:0], operand_a_i[7:4]};
      end
      alu8f_pkg::ACT_SRL: begin
        rot_cy  = operand_a_i[0];
        rot_res = {1'b0, operand_a_i[7:1]};
      end
      default: begin
        rot_cy  = 1'b0;
        rot_res = operand_a_i;
      end
    endcase
  end

  // Decimal adjust: both corrections are chosen from the original accumulator.
  always_comb begin
    daa_u  = 8'd0;
    daa_cy = flags_i.c;
    if (flags_i.h || (!flags_i.n && (operand_a_i[3:0] > alu8f_pkg::DAA_NIB_MAX))) begin
      daa_u = alu8f_pkg::DAA_ADJ_LOW;
    end
    if (flags_i.c || (!flags_i.n && (operand_a_i > alu8f_pkg::DAA_LIMIT))) begin
      daa_u  = daa_u | alu8f_pkg::DAA_ADJ_HIGH;
      daa_cy = 1'b1;
    end
    daa_res = flags_i.n ? (operand_a_i - daa_u) : (operand_a_i + daa_u);
  end

  always_comb begin
    res = operand_a_i;
    fo  = flags_i;
    wr  = 1'b1;
    case (action_i)
      alu8f_pkg::ACT_ADD, alu8f_pkg::ACT_ADC: begin
        res = sum9[7:0];
        fo  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      alu8f_pkg::ACT_SUB, alu8f_pkg::ACT_SBC, alu8f_pkg::ACT_CP: begin
        res = diff9[7:0];
        fo  = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
        if (action_i == alu8f_pkg::ACT_CP) begin
          res = operand_a_i;
          wr  = 1'b0;
        end
      end
      alu8f_pkg::ACT_AND: begin
        res = operand_a_i & operand_b_i;
        fo  = '{z: ((operand_a_i & operand_b_i) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      alu8f_pkg::ACT_XOR: begin
        res = operand_a_i ^ operand_b_i;
        fo  = '{z: ((operand_a_i ^ operand_b_i) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8f_pkg::ACT_OR: begin
        res = operand_a_i | operand_b_i;
        fo  = '{z: ((operand_a_i | operand_b_i) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8f_pkg::ACT_INC: begin
        res = inc8;
        fo  = '{z: (inc8 == 8'd0), n: 1'b0, h: (inc8[3:0] == 4'h0), c: flags_i.c};
      end
      alu8f_pkg::ACT_DEC: begin
        res = dec8;
        fo  = '{z: (dec8 == 8'd0), n: 1'b1, h: (dec8[3:0] == 4'hF), c: flags_i.c};
      end
      alu8f_pkg::ACT_RLC, alu8f_pkg::ACT_RRC, alu8f_pkg::ACT_RL, alu8f_pkg::ACT_RR,
      alu8f_pkg::ACT_SLA, alu8f_pkg::ACT_SRA, alu8f_pkg::ACT_SWAP,
      alu8f_pkg::ACT_SRL: begin
        res = rot_res;
        fo  = '{z: (rot_res == 8'd0), n: 1'b0, h: 1'b0, c: rot_cy};
      end
      // The accumulator rotates always clear Z.
      alu8f_pkg::ACT_RLCA, alu8f_pkg::ACT_RRCA, alu8f_pkg::ACT_RLA,
      alu8f_pkg::ACT_RRA: begin
        res = rot_res;
        fo  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_cy};
      end
      alu8f_pkg::ACT_BIT: begin
        fo = '{z: ((operand_a_i & mask8) == 8'd0), n: 1'b0, h: 1'b1, c: flags_i.c};
        wr = 1'b0;
      end
      alu8f_pkg::ACT_RES: begin
        res = operand_a_i & ~mask8;
      end
      alu8f_pkg::ACT_SET: begin
        res = operand_a_i | mask8;
      end
      alu8f_pkg::ACT_DAA: begin
        res = daa_res;
        fo  = '{z: (daa_res == 8'd0), n: flags_i.n, h: 1'b0, c: daa_cy};
      end
      alu8f_pkg::ACT_CPL: begin
        res = ~operand_a_i;
        fo  = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
      end
      alu8f_pkg::ACT_SCF: begin
        fo = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
        wr = 1'b0;
      end
      alu8f_pkg::ACT_CCF: begin
        fo = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
        wr = 1'b0;
      end
      default: begin
        // Codes with no operation leave everything as it came in.
        wr = 1'b0;
      end
    endcase
  end

  assign out_o = '{value: res, flags: fo, write: wr};

endmodule

`default_nettype wire
